[src/isbnv_pkg.sv]
// Package with the shared types, constants and check functions of the ISBN-13 validator.
`timescale 1ns / 1ps

package isbnv_pkg;

   localparam int CHAR_W  = 8;
   localparam int POS_W   = 5;
   localparam int HYPH_W  = 3;
   localparam int GROUP_W = 3;
   localparam int VALUE_W = 24;
   localparam int WIDE_W  = 27;
   localparam int SUM_W   = 4;
   localparam int DIGIT_W = 4;

   localparam logic [POS_W-1:0]   PREFIX_LEN = 5'd5;
   localparam logic [POS_W-1:0]   TEXT_LEN   = 5'd22;
   localparam logic [POS_W-1:0]   POS_SAT    = 5'd23;
   localparam logic [HYPH_W-1:0]  HYPH_SAT   = 3'd7;
   localparam logic [HYPH_W-1:0]  HYPH_NEED  = 3'd4;
   localparam logic [GROUP_W-1:0] GROUP_LAST = 3'd4;
   localparam logic [VALUE_W-1:0] GROUP_SAT  = 24'd10000000;
   localparam logic [VALUE_W-1:0] EAN_978    = 24'd978;
   localparam logic [VALUE_W-1:0] EAN_979    = 24'd979;

   localparam logic [GROUP_W-1:0] GRP_EAN        = 3'd0;
   localparam logic [GROUP_W-1:0] GRP_REGION     = 3'd1;
   localparam logic [GROUP_W-1:0] GRP_REGISTRANT = 3'd2;

   localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } beat_type;

   function automatic logic [CHAR_W-1:0] prefix_byte(input logic [2:0] idx);
      logic [CHAR_W-1:0] b;
      unique case (idx)
         3'd0:    b = 8'h49;  // I
         3'd1:    b = 8'h53;  // S
         3'd2:    b = 8'h42;  // B
         3'd3:    b = 8'h4E;  // N
         3'd4:    b = 8'h20;  // space
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic in_region(input logic [VALUE_W-1:0] v);
      return (v <= 24'd7) || (v >= 24'd80 && v <= 24'd94) ||
             (v >= 24'd600 && v <= 24'd649) || (v >= 24'd950 && v <= 24'd989) ||
             (v >= 24'd9900 && v <= 24'd9989) || (v >= 24'd99900 && v <= 24'd9999999);
   endfunction

   function automatic logic in_registrant(input logic [VALUE_W-1:0] v);
      return (v <= 24'd19) || (v >= 24'd200 && v <= 24'd699) ||
             (v >= 24'd7000 && v <= 24'd8499) || (v >= 24'd85000 && v <= 24'd89999) ||
             (v >= 24'd900000 && v <= 24'd949999) ||
             (v >= 24'd9500000 && v <= 24'd9999999);
   endfunction

   // The running sum plus one weighted digit never exceeds 36.
   function automatic logic [SUM_W-1:0] mod_ten(input logic [5:0] s);
      logic [5:0] r;
      priority if (s >= 6'd30) r = s - 6'd30;
      else if (s >= 6'd20)     r = s - 6'd20;
      else if (s >= 6'd10)     r = s - 6'd10;
      else                     r = s;
      return r[SUM_W-1:0];
   endfunction

endpackage

[src/isbn13_hyphenated_validator_unit.sv]
// Top level of the hyphenated ISBN-13 validator: input register, scan core, result register.
// A last character passes the input register and then the result register, and it waits
// in the input register while an earlier result beat is stalled at the output.
// Throughput: one character per cycle, unless a last character waits on the output.
// A result beat stalled at the output blocks a beat that ends a text and the requests behind it.
// Reset is synchronous, active high, clears both handshake registers and the scan
// state, so the next character accepted is the first of a new text.
`timescale 1ns / 1ps

module isbn13_hyphenated_validator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_valid
);

   logic                 beat_valid;
   isbnv_pkg::beat_type  beat;
   logic                 advance;
   logic                 ok;
   logic                 result_fire;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_is_valid_ff, rsp_is_valid_in;

   // A beat without a result never waits on the output side.
   assign advance     = beat_valid && (!beat.last_char || !rsp_valid_ff || !rsp_stall);
   assign result_fire = advance && beat.last_char;

   isbnv_input_reg u_input_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .advance       (advance),
      .beat_valid    (beat_valid),
      .beat          (beat)
   );

   isbnv_scan_core u_scan_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .beat    (beat),
      .ok      (ok)
   );

   always_comb begin
      rsp_is_valid_in = result_fire ? ok : rsp_is_valid_ff;
      if (result_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_is_valid_ff <= rsp_is_valid_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_valid = rsp_is_valid_ff;

   a_fire_slot_free: assert property (@(posedge clock) disable iff (reset)
      result_fire |-> !rsp_valid_ff || !rsp_stall)
      else $error("result beat overwritten while stalled");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> beat_valid && beat.last_char && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked result");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(result_fire))
      else $error("result beat without a last character");

endmodule

[src/isbnv_input_reg.sv]
// Input register that holds one request beat until the scan core takes it.
`timescale 1ns / 1ps

module isbnv_input_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_char_code,
   input  logic                    req_last_char,
   input  logic                    advance,
   output logic                    beat_valid,
   output isbnv_pkg::beat_type     beat
);

   logic                 valid_ff, valid_in;
   isbnv_pkg::beat_type  beat_ff, beat_in;
   logic                 load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      beat_in = beat_ff;
      if (load) begin
         beat_in.char_code = req_char_code;
         beat_in.last_char = req_last_char;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

[src/isbnv_scan_core.sv]
// Running scan state of one text and the validity check at its last character.
`timescale 1ns / 1ps

module isbnv_scan_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  isbnv_pkg::beat_type  beat,
   output logic                 ok
);

   logic [isbnv_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                          prefix_ff, prefix_in;
   logic [isbnv_pkg::HYPH_W-1:0]  hyph_ff, hyph_in;
   logic                          digits_ff, digits_in;
   logic [isbnv_pkg::GROUP_W-1:0] group_ff, group_in;
   logic [isbnv_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                          ean_ff, ean_in;
   logic                          region_ff, region_in;
   logic                          regst_ff, regst_in;
   logic                          odd_ff, odd_in;
   logic [isbnv_pkg::SUM_W-1:0]   sum_ff, sum_in;

   logic [isbnv_pkg::DIGIT_W-1:0] digit;
   logic [isbnv_pkg::WIDE_W-1:0]  value_next;
   logic [5:0]                    weighted;
   logic [isbnv_pkg::SUM_W-1:0]   key;
   logic                          is_digit;

   // Digits are 0x30 to 0x39, so the low nibble is the digit value.
   assign digit      = beat.char_code[isbnv_pkg::DIGIT_W-1:0];
   assign is_digit   = beat.char_code >= isbnv_pkg::CHAR_ZERO &&
                       beat.char_code <= isbnv_pkg::CHAR_NINE;
   assign value_next = isbnv_pkg::WIDE_W'(value_ff) * isbnv_pkg::WIDE_W'(10) +
                       isbnv_pkg::WIDE_W'(digit);
   assign weighted   = odd_ff ? 6'(digit) * 6'd3 : 6'(digit);

   always_comb begin
      pos_in    = pos_ff;
      prefix_in = prefix_ff;
      hyph_in   = hyph_ff;
      digits_in = digits_ff;
      group_in  = group_ff;
      value_in  = value_ff;
      ean_in    = ean_ff;
      region_in = region_ff;
      regst_in  = regst_ff;
      odd_in    = odd_ff;
      sum_in    = sum_ff;

      priority if (pos_ff < isbnv_pkg::PREFIX_LEN) begin
         if (beat.char_code != isbnv_pkg::prefix_byte(pos_ff[2:0])) prefix_in = 1'b0;
      end else if (beat.char_code == isbnv_pkg::CHAR_HYPHEN) begin
         if (hyph_ff < isbnv_pkg::HYPH_SAT) hyph_in = hyph_ff + 3'd1;
         unique case (group_ff)
            isbnv_pkg::GRP_EAN:
               ean_in = value_ff == isbnv_pkg::EAN_978 || value_ff == isbnv_pkg::EAN_979;
            isbnv_pkg::GRP_REGION:     region_in = isbnv_pkg::in_region(value_ff);
            isbnv_pkg::GRP_REGISTRANT: regst_in  = isbnv_pkg::in_registrant(value_ff);
            default: ;
         endcase
         if (group_ff < isbnv_pkg::GROUP_LAST) group_in = group_ff + 3'd1;
         value_in = '0;
      end else if (is_digit) begin
         if (value_ff >= isbnv_pkg::GROUP_SAT ||
             value_next > isbnv_pkg::WIDE_W'(isbnv_pkg::GROUP_SAT)) begin
            value_in = isbnv_pkg::GROUP_SAT;
         end else begin
            value_in = value_next[isbnv_pkg::VALUE_W-1:0];
         end
         // Digits of the check group do not enter the weighted sum.
         if (group_ff < isbnv_pkg::GROUP_LAST) begin
            sum_in = isbnv_pkg::mod_ten(6'(sum_ff) + weighted);
            odd_in = !odd_ff;
         end
      end else begin
         digits_in = 1'b0;
      end

      if (pos_ff < isbnv_pkg::POS_SAT) pos_in = pos_ff + 5'd1;

      key = (sum_in == '0) ? '0 : 4'd10 - sum_in;
      ok  = pos_in == isbnv_pkg::TEXT_LEN && prefix_in && digits_in &&
            hyph_in == isbnv_pkg::HYPH_NEED && ean_in && region_in && regst_in &&
            value_in == isbnv_pkg::VALUE_W'(key);
   end

   // State returns to its start values after the last character of each text.
   always_ff @(posedge clock) begin
      if (reset || (advance && beat.last_char)) begin
         pos_ff    <= '0;
         prefix_ff <= 1'b1;
         hyph_ff   <= '0;
         digits_ff <= 1'b1;
         group_ff  <= '0;
         value_ff  <= '0;
         ean_ff    <= 1'b0;
         region_ff <= 1'b0;
         regst_ff  <= 1'b0;
         odd_ff    <= 1'b0;
         sum_ff    <= '0;
      end else if (advance) begin
         pos_ff    <= pos_in;
         prefix_ff <= prefix_in;
         hyph_ff   <= hyph_in;
         digits_ff <= digits_in;
         group_ff  <= group_in;
         value_ff  <= value_in;
         ean_ff    <= ean_in;
         region_ff <= region_in;
         regst_ff  <= regst_in;
         odd_ff    <= odd_in;
         sum_ff    <= sum_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= isbnv_pkg::POS_SAT)
      else $error("character position beyond saturation");

   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      value_ff <= isbnv_pkg::GROUP_SAT)
      else $error("group value beyond saturation");

   a_text_restart: assert property (@(posedge clock) disable iff (reset)
      advance && beat.last_char |=> pos_ff == '0 && sum_ff == '0 && prefix_ff)
      else $error("scan state not cleared after last character");

   a_no_prefix_sum: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= isbnv_pkg::PREFIX_LEN |-> sum_ff == '0 && hyph_ff == '0)
      else $error("prefix characters changed group state");

endmodule
